// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. Simulation builds expand them, synthesis
// builds (SYNTH defined) drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication: a trigger must be followed by a condition in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)
`endif

`endif

// ===== rtl/kse_pkg.sv =====
// ----------------------------------------------------------------------------
// kse_pkg
// Types, constants and helper functions of the keypad scanner / number entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kse_pkg;

    // Highest cursor line
    localparam logic [2:0]  LAST_LINE  = 3'd4;
    // Entry saturation limit
    localparam logic [19:0] ENTRY_MAX  = 20'd999999;
    // ceil(2^23 / 10): x / 10 == (x * DIV10_RECIP) >> 23 for any 20-bit x
    localparam logic [19:0] DIV10_RECIP = 20'd838861;

    // Key codes
    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_B    = 4'd11;
    localparam logic [3:0] KEY_C    = 4'd12;
    localparam logic [3:0] KEY_D    = 4'd13;
    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCAN_PERIOD   = 2'd0,
        CFG_DEBOUNCE      = 2'd1,
        CFG_RELEASE_POLL  = 2'd2
    } t_cfg_index;

    // Host commands
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } t_cmd;

    // Key service phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SETTLE  = 2'd1,
        PH_RELEASE = 2'd2,
        PH_AFTER   = 2'd3
    } t_key_phase;

    typedef struct packed {
        logic [19:0] scan_period;
        logic [19:0] debounce_ticks;
        logic [15:0] release_poll_ticks;
    } t_cfg;

    typedef struct packed {
        logic [3:0] column_levels;
        logic       entry_locked;
    } t_item;

    typedef struct packed {
        logic [3:0]  row_lines;
        logic        key_valid;
        logic [3:0]  key_code;
        logic [19:0] entry_value;
        logic [19:0] confirmed_value;
        logic        confirmed_pulse;
        logic [2:0]  cursor_line;
        logic [1:0]  command;
    } t_result;

    // Key code at a column / row crossing
    function automatic logic [3:0] key_lookup(input logic [1:0] col, input logic [1:0] row);
        logic [3:0] code;
        case ({col, row})
            4'h0:    code = 4'd1;
            4'h1:    code = 4'd4;
            4'h2:    code = 4'd7;
            4'h3:    code = KEY_STAR;
            4'h4:    code = 4'd2;
            4'h5:    code = 4'd5;
            4'h6:    code = 4'd8;
            4'h7:    code = 4'd0;
            4'h8:    code = 4'd3;
            4'h9:    code = 4'd6;
            4'hA:    code = 4'd9;
            4'hB:    code = KEY_HASH;
            4'hC:    code = KEY_A;
            4'hD:    code = KEY_B;
            4'hE:    code = KEY_C;
            4'hF:    code = KEY_D;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

    // Cursor step up, held at the last line
    function automatic logic [2:0] line_next(input logic [2:0] line);
        return (line >= LAST_LINE) ? LAST_LINE : line + 3'd1;
    endfunction

    // Lowest set bit of a 4-bit vector (3 when only bit 3 or none)
    function automatic logic [1:0] lowest_bit(input logic [3:0] vec);
        logic [1:0] idx;
        if (vec[0])      idx = 2'd0;
        else if (vec[1]) idx = 2'd1;
        else if (vec[2]) idx = 2'd2;
        else             idx = 2'd3;
        return idx;
    endfunction

endpackage

// ===== rtl/keypad_scan_number_entry_core.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_number_entry_core
// 4x4 matrix keypad scanner with debounce and decimal number entry.
// ----------------------------------------------------------------------------
// Each request on the input channel is one 1 us tick carrying the column
// levels and the entry-lock flag; each tick gives exactly one result. The
// block takes one tick per clock cycle, back to back, unless stalled: a
// request lands in an input register, the scan timer and key machine update
// in one pass, and the result is held in an output register. The input
// register takes a new request in the same cycle its current one moves on;
// while a result waits to be taken and the input register is full, the input
// stalls (the input stall follows the output stall in the same cycle).
// Configuration writes are taken in any cycle (ready is always high) and act
// from the next tick; after reset the scan period is 10000, debounce 1000,
// release poll 100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_scan_number_entry_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // tick requests
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  kse_pkg::t_item    i_in_item,
    // results
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output kse_pkg::t_result  o_out_item,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [19:0]       i_cfg_data
);
    import kse_pkg::*;

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_item    r_in_item;
    logic     r_out_valid;
    t_result  r_out_item;

    logic     advance;
    logic     step;
    logic     idle;
    logic [3:0] row_drive;
    t_result  result;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_period        <= 20'd10000;
            r_cfg.debounce_ticks     <= 20'd1000;
            r_cfg.release_poll_ticks <= 16'd100;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SCAN_PERIOD:  r_cfg.scan_period        <= i_cfg_data;
                CFG_DEBOUNCE:     r_cfg.debounce_ticks     <= i_cfg_data;
                CFG_RELEASE_POLL: r_cfg.release_poll_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Flow control: process when the output register is free or draining
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    kse_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_idle      (idle),
        .i_cfg       (r_cfg),
        .o_row_drive (row_drive)
    );

    kse_key u_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in_item),
        .i_cfg       (r_cfg),
        .i_row_drive (row_drive),
        .o_idle      (idle),
        .o_result    (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/kse_scan.sv =====
// ----------------------------------------------------------------------------
// kse_scan
// Row scan timer. Rotates the one-hot row drive every scan period, holding
// a due rotation back while a key is in service.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kse_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_idle,
    input  kse_pkg::t_cfg  i_cfg,
    output logic [3:0]     o_row_drive
);
    import kse_pkg::*;

    logic [19:0] r_scan_timer, n_scan_timer;
    logic        r_rotate_pending, n_rotate_pending;
    logic [1:0]  r_row_phase, n_row_phase;
    logic [3:0]  r_row_drive, n_row_drive;

    logic [19:0] period;
    logic [20:0] timer_inc;
    logic        wrap, pend, rotate;

    // Timer and rotation for this tick
    always_comb begin
        period           = (i_cfg.scan_period == 20'd0) ? 20'd1 : i_cfg.scan_period;
        timer_inc        = {1'b0, r_scan_timer} + 21'd1;
        wrap             = timer_inc >= {1'b0, period};
        n_scan_timer     = wrap ? 20'd0 : timer_inc[19:0];
        pend             = wrap | r_rotate_pending;
        rotate           = pend & i_idle;
        n_row_drive      = rotate ? (4'b0001 << r_row_phase) : r_row_drive;
        n_row_phase      = rotate ? r_row_phase + 2'd1 : r_row_phase;
        n_rotate_pending = pend & ~rotate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_timer     <= '0;
            r_rotate_pending <= 1'b0;
            r_row_phase      <= '0;
            r_row_drive      <= '0;
        end else if (i_step) begin
            r_scan_timer     <= n_scan_timer;
            r_rotate_pending <= n_rotate_pending;
            r_row_phase      <= n_row_phase;
            r_row_drive      <= n_row_drive;
        end
    end

    // Row drive after this tick's rotation
    assign o_row_drive = n_row_drive;

    `ASSERT_PROP(a_row_onehot, i_clk, i_rst_n, $onehot0(r_row_drive), "row drive not one-hot")
    `ASSERT_PROP(a_row_phase, i_clk, i_rst_n, (r_row_drive == 4'd0) || (r_row_drive == (4'b0001 << (r_row_phase - 2'd1))), "row drive out of step with phase")
    `ASSERT_NEXT(a_hold_busy, i_clk, i_rst_n, i_step && !i_idle, r_row_drive == $past(r_row_drive), "row rotated during key service")

endmodule

// ===== rtl/kse_key.sv =====
// ----------------------------------------------------------------------------
// kse_key
// Column edge capture, debounce / release state machine, key decode and
// decimal number entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kse_key (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  kse_pkg::t_item    i_item,
    input  kse_pkg::t_cfg     i_cfg,
    input  logic [3:0]        i_row_drive,
    output logic              o_idle,
    output kse_pkg::t_result  o_result
);
    import kse_pkg::*;

    t_key_phase  r_phase, n_phase;
    logic [19:0] r_wait, n_wait;
    logic [3:0]  r_cols_before;
    logic [3:0]  r_edges, n_edges;
    logic [1:0]  r_served, n_served;
    logic [19:0] r_typed, n_typed;
    logic [19:0] r_latched, n_latched;
    logic [2:0]  r_line, n_line;

    logic [3:0]  edges;
    logic [1:0]  sel_col;
    logic [19:0] wait_dec;
    logic        wait_done;
    logic        col_high;
    logic        key_hit;
    logic [1:0]  row_idx;
    logic [3:0]  code;
    logic [15:0] poll;
    logic [23:0] digit_sum;
    logic [39:0] div_prod;
    logic [19:0] tenth;

    // Shared conditions
    always_comb begin
        edges     = r_edges | (i_item.column_levels & ~r_cols_before);
        sel_col   = lowest_bit(edges);
        wait_dec  = (r_wait != 20'd0) ? r_wait - 20'd1 : r_wait;
        wait_done = wait_dec == 20'd0;
        col_high  = i_item.column_levels[r_served];
        poll      = (i_cfg.release_poll_ticks == 16'd0) ? 16'd1 : i_cfg.release_poll_ticks;
        key_hit   = (r_phase == PH_SETTLE) && wait_done && col_high && (i_row_drive != 4'd0);
        row_idx   = lowest_bit(i_row_drive);
        code      = key_lookup(r_served, row_idx);
    end

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_wait   = r_wait;
        n_edges  = edges;
        n_served = r_served;
        case (r_phase)
            PH_IDLE: begin
                if (edges != 4'd0) begin
                    n_edges  = edges & ~(4'b0001 << sel_col);
                    n_served = sel_col;
                    n_wait   = i_cfg.debounce_ticks;
                    n_phase  = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                n_wait = wait_dec;
                if (wait_done) begin
                    if (col_high) begin
                        n_wait  = 20'd0;
                        n_phase = PH_RELEASE;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_RELEASE: begin
                n_wait = wait_dec;
                if (wait_done) begin
                    if (col_high) begin
                        n_wait = {4'd0, poll};
                    end else begin
                        n_wait  = i_cfg.debounce_ticks;
                        n_phase = PH_AFTER;
                    end
                end
            end
            PH_AFTER: begin
                n_wait = wait_dec;
                if (wait_done) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Key actions and result
    always_comb begin
        digit_sum = ({4'd0, r_typed} << 3) + ({4'd0, r_typed} << 1) + {20'd0, code};
        div_prod  = r_typed * DIV10_RECIP;
        tenth     = {3'd0, div_prod[39:23]};
        n_typed   = r_typed;
        n_latched = r_latched;
        n_line    = r_line;
        o_result  = '0;
        o_result.command = CMD_NONE;
        if (key_hit) begin
            o_result.key_valid = 1'b1;
            o_result.key_code  = code;
            if (code <= KEY_LAST_DIGIT) begin
                n_typed = (digit_sum > {4'd0, ENTRY_MAX}) ? ENTRY_MAX : digit_sum[19:0];
            end else begin
                case (code)
                    KEY_STAR: n_typed = tenth;
                    KEY_HASH: begin
                        n_latched = r_typed;
                        n_typed   = 20'd0;
                        n_line    = line_next(r_line);
                        o_result.confirmed_pulse = 1'b1;
                    end
                    KEY_A: o_result.command = CMD_START;
                    KEY_B: o_result.command = CMD_STOP;
                    KEY_C: begin
                        if (!i_item.entry_locked && r_line != 3'd0) n_line = r_line - 3'd1;
                    end
                    default: begin
                        if (!i_item.entry_locked) n_line = line_next(r_line);
                    end
                endcase
            end
        end
        o_result.row_lines       = i_row_drive;
        o_result.entry_value     = n_typed;
        o_result.confirmed_value = n_latched;
        o_result.cursor_line     = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_wait        <= '0;
            r_cols_before <= '0;
            r_edges       <= '0;
            r_served      <= '0;
            r_typed       <= '0;
            r_latched     <= '0;
            r_line        <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_wait        <= n_wait;
            r_cols_before <= i_item.column_levels;
            r_edges       <= n_edges;
            r_served      <= n_served;
            r_typed       <= n_typed;
            r_latched     <= n_latched;
            r_line        <= n_line;
        end
    end

    assign o_idle = r_phase == PH_IDLE;

    `ASSERT_PROP(a_line_range, i_clk, i_rst_n, r_line <= LAST_LINE, "cursor past last line")
    `ASSERT_PROP(a_entry_range, i_clk, i_rst_n, r_typed <= ENTRY_MAX, "entry over limit")
    `ASSERT_NEXT(a_hit_release, i_clk, i_rst_n, i_step && key_hit, r_phase == PH_RELEASE, "accepted key not followed by release wait")

endmodule

// ===== tb/keypad_entry_checker.sv =====
// ----------------------------------------------------------------------------
// keypad_entry_checker
// Watches the tick, result and configuration channels of the keypad scanner.
// It keeps its own copy of the scanner state, predicts the result of every
// accepted tick request, and compares each accepted result field by field
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_entry_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  kse_pkg::t_item    i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  kse_pkg::t_result  i_out_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [19:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_pending_count
);

    import kse_pkg::*;

    // Key at column c, row r sits at index c*4 + r
    localparam logic [0:15][3:0] KEY_GRID = {
        4'd1, 4'd4, 4'd7, KEY_STAR,
        4'd2, 4'd5, 4'd8, 4'd0,
        4'd3, 4'd6, 4'd9, KEY_HASH,
        KEY_A, KEY_B, KEY_C, KEY_D
    };

    // Register copies
    int unsigned scan_len, settle_len, poll_len;

    // Scanner state copy
    int unsigned tick_count, countdown, number, number_held;
    logic        rotate_due;
    logic [1:0]  next_row;
    logic [3:0]  rows_now, cols_prev, edges_seen;
    t_key_phase  key_state;
    logic [1:0]  col_sel;
    logic [2:0]  cursor;

    t_result tick_results_due[$];
    int      fail_total = 0;

    // Cursor step up, held at the last line
    function automatic logic [2:0] cursor_up(input logic [2:0] cur);
        return (cur >= LAST_LINE) ? LAST_LINE : cur + 3'd1;
    endfunction

    task automatic clear_state();
        scan_len    = 10000;
        settle_len  = 1000;
        poll_len    = 100;
        tick_count  = 0;
        countdown   = 0;
        number      = 0;
        number_held = 0;
        rotate_due  = 1'b0;
        next_row    = 2'd0;
        rows_now    = 4'd0;
        cols_prev   = 4'd0;
        edges_seen  = 4'd0;
        key_state   = PH_IDLE;
        col_sel     = 2'd0;
        cursor      = 3'd0;
    endtask

    // Apply one accepted key to the number, cursor and command
    task automatic apply_key(input logic [3:0] code, input logic locked,
                             inout t_result res);
        int unsigned grown;
        if (code <= KEY_LAST_DIGIT) begin
            grown  = number * 10 + code;
            number = (grown > ENTRY_MAX) ? ENTRY_MAX : grown;
        end else begin
            case (code)
                KEY_STAR: number = number / 10;
                KEY_HASH: begin
                    number_held         = number;
                    number              = 0;
                    res.confirmed_pulse = 1'b1;
                    cursor              = cursor_up(cursor);
                end
                KEY_A: res.command = CMD_START;
                KEY_B: res.command = CMD_STOP;
                KEY_C: begin
                    if (!locked && cursor >= 3'd1) cursor = cursor - 3'd1;
                end
                default: begin
                    if (!locked) cursor = cursor_up(cursor);
                end
            endcase
        end
    endtask

    // One tick: edge latch, scan rotation, key machine, then outputs
    task automatic scan_tick(input t_item it, output t_result res);
        int unsigned period, poll;
        logic [3:0]  cols;
        logic        idle_at_start;
        logic [1:0]  row_idx;
        logic [3:0]  code;
        cols          = it.column_levels;
        period        = (scan_len == 0) ? 1 : scan_len;
        poll          = (poll_len == 0) ? 1 : poll_len;
        res           = '0;
        idle_at_start = (key_state == PH_IDLE);

        edges_seen = edges_seen | (cols & ~cols_prev);
        cols_prev  = cols;

        if (tick_count + 1 >= period) begin
            tick_count = 0;
            rotate_due = 1'b1;
        end else begin
            tick_count = tick_count + 1;
        end
        // rotation waits while a key is being served
        if (rotate_due && idle_at_start) begin
            rows_now   = 4'd1 << next_row;
            next_row   = next_row + 2'd1;
            rotate_due = 1'b0;
        end

        case (key_state)
            PH_IDLE: begin
                if (edges_seen != 4'd0) begin
                    col_sel = 2'd0;
                    while (col_sel < 2'd3 && !edges_seen[col_sel]) col_sel = col_sel + 2'd1;
                    edges_seen[col_sel] = 1'b0;
                    countdown = settle_len;
                    key_state = PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                if (countdown != 0) countdown = countdown - 1;
                if (countdown == 0) begin
                    if (cols[col_sel]) begin
                        // no row driven: served, but no key comes out
                        if (rows_now != 4'd0) begin
                            row_idx = 2'd0;
                            while (row_idx < 2'd3 && !rows_now[row_idx])
                                row_idx = row_idx + 2'd1;
                            code          = KEY_GRID[{col_sel, row_idx}];
                            res.key_valid = 1'b1;
                            res.key_code  = code;
                            apply_key(code, it.entry_locked, res);
                        end
                        countdown = 0;
                        key_state = PH_RELEASE;
                    end else begin
                        // column dropped during settle: edge discarded
                        key_state = PH_IDLE;
                    end
                end
            end
            PH_RELEASE: begin
                if (countdown != 0) countdown = countdown - 1;
                if (countdown == 0) begin
                    if (cols[col_sel]) begin
                        countdown = poll;
                    end else begin
                        countdown = settle_len;
                        key_state = PH_AFTER;
                    end
                end
            end
            default: begin
                if (countdown != 0) countdown = countdown - 1;
                if (countdown == 0) key_state = PH_IDLE;
            end
        endcase

        res.row_lines       = rows_now;
        res.entry_value     = number[19:0];
        res.confirmed_value = number_held[19:0];
        res.cursor_line     = cursor;
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            fail_total++;
            if (fail_total <= 10)
                $display("%0t: %s differs: expected %0d, actual %0d",
                         $realtime, name, want_v, got_v);
        end
    endtask

    // Channel watch: config writes, tick requests, results
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            tick_results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SCAN_PERIOD:  scan_len   = i_cfg_data;
                    CFG_DEBOUNCE:     settle_len = i_cfg_data;
                    CFG_RELEASE_POLL: poll_len   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                scan_tick(i_in_item, want);
                tick_results_due.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (tick_results_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result with no tick waiting: %p", $realtime, i_out_item);
                end else begin
                    want = tick_results_due.pop_front();
                    check_field("row_lines", want.row_lines, i_out_item.row_lines);
                    check_field("key_valid", want.key_valid, i_out_item.key_valid);
                    check_field("key_code", want.key_code, i_out_item.key_code);
                    check_field("entry_value", want.entry_value, i_out_item.entry_value);
                    check_field("confirmed_value", want.confirmed_value,
                                i_out_item.confirmed_value);
                    check_field("confirmed_pulse", want.confirmed_pulse,
                                i_out_item.confirmed_pulse);
                    check_field("cursor_line", want.cursor_line, i_out_item.cursor_line);
                    check_field("command", want.command, i_out_item.command);
                end
            end
        end
        o_pending_count <= tick_results_due.size();
        o_fail_count    <= fail_total;
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keypad scanner / number entry core. Feeds tick
// requests (directed first, then random key presses with bounce and noise)
// under several timing settings, idles and stalls both channels at random,
// and lets the checker predict and compare every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import kse_pkg::*;

    // {column_levels, entry_locked}; settle 1, poll 1, rotation every 3 ticks
    localparam logic [0:23][4:0] DIRECTED_TICKS = {
        5'b0000_0, 5'b0001_1, 5'b0001_1, 5'b0001_0, 5'b0000_0, 5'b0000_0,
        5'b0000_0, 5'b1111_0, 5'b1111_1, 5'b1111_0, 5'b1111_0, 5'b0000_0,
        5'b0000_0, 5'b0000_1, 5'b0010_1, 5'b0010_1, 5'b0010_1, 5'b0000_0,
        5'b0000_0, 5'b1000_1, 5'b1000_1, 5'b0000_1, 5'b0100_0, 5'b0100_0
    };
    localparam int PHASES = 12;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_item       in_item   = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_result     out_item;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_data  = '0;
    logic        cfg_ready;

    int fail_count;
    int pending_count;

    int          ticks_sent    = 0;
    bit          sender_idles  = 1'b1;
    bit          steady        = 1'b0;
    bit          hold_request  = 1'b0;
    bit          digit_bias    = 1'b0;
    int unsigned cur_deb       = 0;
    int unsigned cur_poll      = 0;

    keypad_scan_number_entry_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    keypad_entry_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial begin
        #2_400_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 90;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (steady) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 37);
            end
        end
    end

    // One tick request, with random idle cycles ahead of it
    task automatic send_tick(input logic [3:0] cols, input logic locked);
        while (sender_idles && $urandom_range(0, 99) < 37) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {cols, locked};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [19:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_timing(input int unsigned scan, input int unsigned deb,
                              input int unsigned poll);
        write_reg(CFG_SCAN_PERIOD, scan[19:0]);
        write_reg(CFG_DEBOUNCE, deb[19:0]);
        write_reg(CFG_RELEASE_POLL, {4'd0, poll[15:0]});
        cfg_valid <= 1'b0;
        cur_deb  = deb;
        cur_poll = poll;
    endtask

    // Stop offering and wait out every pending result
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Key press: bounce, hold (short or long), release gap
    task automatic press_key(input logic [3:0] mask, input logic locked);
        int unsigned span, n;
        int          k;
        span = cur_deb + 3 * cur_poll + 6;
        if (span > 60) span = 60;
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
            send_tick($urandom_range(0, 1) ? mask : 4'b0000, locked);
        n = $urandom_range(0, span);
        for (k = 0; k < n; k++)
            send_tick(($urandom_range(0, 9) == 0) ? (mask | 4'($urandom())) : mask,
                      locked ^ ($urandom_range(0, 7) == 0));
        n = $urandom_range(0, span);
        for (k = 0; k < n; k++)
            send_tick(4'b0000, locked);
    endtask

    initial begin : stimulus
        int          p, k, phase_end, hold_at;
        logic [3:0]  mask;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: no row driven yet, all columns at once, lock on and off
        set_timing(3, 1, 1);
        for (k = 0; k < 24; k++)
            send_tick(DIRECTED_TICKS[k][4:1], DIRECTED_TICKS[k][0]);
        drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:          set_timing(0, 0, 0);
                1:          set_timing(1, 1, 1);
                3:          set_timing(20'hFFFFF, 0, 2);
                PHASES - 1: set_timing(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
                default:    set_timing($urandom_range(2, 12), $urandom_range(0, 6),
                                       $urandom_range(0, 4));
            endcase
            sender_idles = (p != 2);
            steady       = (p == 2);
            digit_bias   = (p == 5 || p == 8);
            phase_end    = ticks_sent + ((p == PHASES - 1) ? 40 : 160);
            hold_at      = (p == 6) ? ticks_sent + 40 : -1;
            while (ticks_sent < phase_end) begin
                if (hold_at >= 0 && ticks_sent >= hold_at) begin
                    hold_request = 1'b1;
                    hold_at      = -1;
                end
                if ($urandom_range(0, 9) < 8) begin
                    if (digit_bias && $urandom_range(0, 9) < 7)
                        mask = 4'b0010;
                    else if ($urandom_range(0, 9) == 0)
                        mask = 4'($urandom());
                    else
                        mask = 4'd1 << $urandom_range(0, 3);
                    press_key(mask, 1'($urandom_range(0, 1)));
                end else begin
                    // bursts of line noise
                    k = $urandom_range(1, 6);
                    repeat (k) send_tick(4'($urandom()), 1'($urandom_range(0, 1)));
                end
            end
            drain();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
